/* design/tps_pkg.sv */
// ----------------------------------------------------------------------------
// tps_pkg: shared types and constants of the three-point smoother
// Sample width, transaction structs, mode and register codes, fixed weights.
// ----------------------------------------------------------------------------
package tps_pkg;

    localparam int SAMPLE_W = 16;
    localparam int WEIGHT_W = 16;
    localparam int CFG_IDX_W = 2;

    // mode codes; the unused code behaves as linear
    localparam logic [1:0] MODE_LINEAR = 2'd0;
    localparam logic [1:0] MODE_MEDIAN = 2'd1;
    localparam logic [1:0] MODE_ORDER  = 2'd2;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] REG_MODE          = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_CENTER_WEIGHT = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_SIDE_WEIGHT   = 2'd2;

    // register reset values
    localparam logic [1:0]          MODE_RESET          = MODE_LINEAR;
    localparam logic [WEIGHT_W-1:0] CENTER_WEIGHT_RESET = 16'd45875;
    localparam logic [WEIGHT_W-1:0] SIDE_WEIGHT_RESET   = 16'd9830;

    // fixed order-statistic weights, Q0.16
    localparam logic [WEIGHT_W-1:0] OS_EDGE_WEIGHT = 16'd9830;
    localparam logic [WEIGHT_W-1:0] OS_MID_WEIGHT  = 16'd45875;

    // how many samples of the current series are held
    typedef enum logic [1:0] {
        PHASE_EMPTY = 2'd0,
        PHASE_ONE   = 2'd1,
        PHASE_TWO   = 2'd2
    } phase_t;

    typedef struct packed {
        logic signed [SAMPLE_W-1:0] sample;
        logic                       last;
    } in_t;

    typedef struct packed {
        logic signed [SAMPLE_W-1:0] smoothed;
        logic                       series_end;
    } out_t;

    // one window waiting for the arithmetic stage
    typedef struct packed {
        logic signed [SAMPLE_W-1:0] a;
        logic signed [SAMPLE_W-1:0] b;
        logic signed [SAMPLE_W-1:0] c;
        logic                       pass;
        logic                       series_end;
    } job_t;

endpackage

/* design/tps_calc.sv */
// ----------------------------------------------------------------------------
// tps_calc: window arithmetic of the three-point smoother
// Sorts the window and gives its median, a rounded and saturated weighted sum, or the centre sample.
// ----------------------------------------------------------------------------
module tps_calc (
    input  tps_pkg::job_t                        job,
    input  logic [1:0]                           mode,
    input  logic [tps_pkg::WEIGHT_W-1:0]         center_weight,
    input  logic [tps_pkg::WEIGHT_W-1:0]         side_weight,
    output logic signed [tps_pkg::SAMPLE_W-1:0]  smoothed
);
    import tps_pkg::*;

    localparam int PW = SAMPLE_W + WEIGHT_W + 2;
    localparam int AW = SAMPLE_W + WEIGHT_W + 3;
    localparam int QW = AW - WEIGHT_W;
    localparam logic signed [AW-1:0] ROUND_HALF = AW'(1) <<< (WEIGHT_W - 1);

    logic signed [SAMPLE_W-1:0] lo_ab;
    logic signed [SAMPLE_W-1:0] hi_ab;
    logic signed [SAMPLE_W-1:0] mn;
    logic signed [SAMPLE_W-1:0] mx;
    logic signed [SAMPLE_W-1:0] md;
    logic signed [SAMPLE_W:0]   side_sum;
    logic signed [SAMPLE_W-1:0] mid;
    logic signed [WEIGHT_W:0]   w_side;
    logic signed [WEIGHT_W:0]   w_mid;
    logic signed [PW-1:0]       p_side;
    logic signed [PW-1:0]       p_mid;
    logic signed [AW-1:0]       acc;
    logic signed [QW-1:0]       q;
    logic                       pos_ovf;
    logic                       neg_ovf;
    logic signed [SAMPLE_W-1:0] sat;

    // three-sample sort
    always_comb
    begin
        lo_ab = (job.a < job.b) ? job.a : job.b;
        hi_ab = (job.a < job.b) ? job.b : job.a;
        mn    = (job.c < lo_ab) ? job.c : lo_ab;
        mx    = (job.c > hi_ab) ? job.c : hi_ab;
        if (job.c <= lo_ab)
            md = lo_ab;
        else if (job.c >= hi_ab)
            md = hi_ab;
        else
            md = job.c;
    end

    // the linear and order-statistic modes share the two multipliers: side pair and middle term
    always_comb
    begin
        if (mode == MODE_ORDER)
        begin
            side_sum = (SAMPLE_W + 1)'(mn) + (SAMPLE_W + 1)'(mx);
            mid      = md;
            w_side   = signed'({1'b0, OS_EDGE_WEIGHT});
            w_mid    = signed'({1'b0, OS_MID_WEIGHT});
        end
        else
        begin
            side_sum = (SAMPLE_W + 1)'(job.a) + (SAMPLE_W + 1)'(job.c);
            mid      = job.b;
            w_side   = signed'({1'b0, side_weight});
            w_mid    = signed'({1'b0, center_weight});
        end
    end

    assign p_side = PW'(side_sum) * PW'(w_side);
    assign p_mid  = PW'(mid) * PW'(w_mid);
    assign acc    = AW'(p_side) + AW'(p_mid) + ROUND_HALF;
    assign q      = acc[AW-1:WEIGHT_W];

    assign pos_ovf = !q[QW-1] && (|q[QW-2:SAMPLE_W-1]);
    assign neg_ovf = q[QW-1] && !(&q[QW-2:SAMPLE_W-1]);

    always_comb
    begin
        if (pos_ovf)
            sat = signed'({1'b0, {(SAMPLE_W - 1){1'b1}}});
        else if (neg_ovf)
            sat = signed'({1'b1, {(SAMPLE_W - 1){1'b0}}});
        else
            sat = q[SAMPLE_W-1:0];
    end

    always_comb
    begin
        if (job.pass || (!job.series_end && 1'b0))
            smoothed = job.b;
        else if (mode == MODE_MEDIAN)
            smoothed = md;
        else
            smoothed = sat;
    end

endmodule

/* design/three_point_smoother.sv */
// ----------------------------------------------------------------------------
// three_point_smoother: three-point median / weighted smoothing filter
// Filters a series of signed samples over a window of three, one sample late.
// ----------------------------------------------------------------------------
// Usage:
//   in_valid/in_stall carry samples with a last mark; out_valid/out_stall
//   carry filtered samples with series_end. A transaction moves when valid
//   is high and stall is low. cfg_valid/cfg_ready write mode (index 0),
//   center_weight (1) and side_weight (2); cfg_ready is always high, and
//   writes belong to idle periods only.
//   The first sample of a series gives no result unless it is also the
//   last, when it passes straight through; each later sample gives the
//   result of the one before it, and a last sample gives one more.
//   The window register loads a result's window at the edge that accepts
//   the sample completing it, and the sort, multiply and saturate logic
//   then fills the output register as it frees. The second result of a
//   last sample waits in the pending register until the window register
//   frees. Throughput: one sample per cycle while the receiver keeps up;
//   a last sample of a series that is longer than one holds in_stall high
//   while its second result enters the window register.
//   A stalled receiver holds the output register; the window register and
//   input follow as space runs out, through in_stall.
//   Reset empties the window, pending and output registers, drops any
//   partial series and restores the register defaults.
// ----------------------------------------------------------------------------
module three_point_smoother (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_stall,
    input  tps_pkg::in_t                  in_data,
    output logic                          out_valid,
    input  logic                          out_stall,
    output tps_pkg::out_t                 out_data,
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [tps_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [tps_pkg::WEIGHT_W-1:0]  cfg_data
);
    import tps_pkg::*;

    logic [1:0]          mode_reg;
    logic [WEIGHT_W-1:0] center_weight_reg;
    logic [WEIGHT_W-1:0] side_weight_reg;

    phase_t                     phase_reg,  phase_next;
    logic signed [SAMPLE_W-1:0] older_reg,  older_next;
    logic signed [SAMPLE_W-1:0] newer_reg,  newer_next;
    logic                       job_valid_reg,  job_valid_next;
    job_t                       job_reg,        job_next;
    logic                       pend_valid_reg, pend_valid_next;
    job_t                       pend_reg,       pend_next;
    logic                       out_valid_reg,  out_valid_next;
    out_t                       out_data_reg,   out_data_next;

    logic                       accept;
    logic                       r_ready;
    logic                       j_free;
    logic                       med;
    logic                       has0;
    logic                       has1;
    job_t                       job0;
    job_t                       job1;
    logic signed [SAMPLE_W-1:0] x;
    logic signed [SAMPLE_W-1:0] calc_out;

    assign r_ready   = !out_valid_reg || !out_stall;
    assign j_free    = !job_valid_reg || r_ready;
    assign in_stall  = pend_valid_reg || !j_free;
    assign accept    = in_valid && !in_stall;
    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;
    assign cfg_ready = 1'b1;

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg          <= MODE_RESET;
            center_weight_reg <= CENTER_WEIGHT_RESET;
            side_weight_reg   <= SIDE_WEIGHT_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                REG_MODE:          mode_reg          <= cfg_data[1:0];
                REG_CENTER_WEIGHT: center_weight_reg <= cfg_data;
                REG_SIDE_WEIGHT:   side_weight_reg   <= cfg_data;
                default:           ;
            endcase
        end
    end

    // window bookkeeping: build up to two windows per accepted sample
    always_comb
    begin
        x          = in_data.sample;
        med        = (mode_reg == MODE_MEDIAN);
        has0       = 1'b0;
        has1       = 1'b0;
        job0       = '{a: x, b: x, c: x, pass: 1'b1, series_end: 1'b1};
        job1       = '{a: newer_reg, b: x, c: x, pass: med, series_end: 1'b1};
        phase_next = phase_reg;
        older_next = older_reg;
        newer_next = newer_reg;

        if (accept)
        begin
            if (phase_reg == PHASE_EMPTY)
            begin
                // a one-sample series passes straight through
                has0 = in_data.last;
                if (!in_data.last)
                begin
                    newer_next = x;
                    phase_next = PHASE_ONE;
                end
            end
            else
            begin
                has0 = 1'b1;
                if (phase_reg == PHASE_ONE)
                    job0 = '{a: newer_reg, b: newer_reg, c: x, pass: med, series_end: 1'b0};
                else
                    job0 = '{a: older_reg, b: newer_reg, c: x, pass: 1'b0, series_end: 1'b0};

                if (in_data.last)
                begin
                    has1       = 1'b1;
                    phase_next = PHASE_EMPTY;
                end
                else
                begin
                    older_next = newer_reg;
                    newer_next = x;
                    phase_next = PHASE_TWO;
                end
            end
        end
    end

    // window register and the second window of a series end
    always_comb
    begin
        job_valid_next  = job_valid_reg && !r_ready;
        job_next        = job_reg;
        pend_valid_next = pend_valid_reg;
        pend_next       = pend_reg;

        if (j_free)
        begin
            if (pend_valid_reg)
            begin
                job_next        = pend_reg;
                job_valid_next  = 1'b1;
                pend_valid_next = 1'b0;
            end
            else if (accept && has0)
            begin
                job_next        = job0;
                job_valid_next  = 1'b1;
                pend_valid_next = has1;
                pend_next       = job1;
            end
        end
    end

    tps_calc u_calc (
        .job           (job_reg),
        .mode          (mode_reg),
        .center_weight (center_weight_reg),
        .side_weight   (side_weight_reg),
        .smoothed      (calc_out)
    );

    // output register: advance whenever the receiver takes or it is empty
    always_comb
    begin
        out_valid_next = out_valid_reg;
        out_data_next  = out_data_reg;
        if (r_ready)
        begin
            out_valid_next = job_valid_reg;
            out_data_next  = '{smoothed: calc_out, series_end: job_reg.series_end};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg      <= PHASE_EMPTY;
            job_valid_reg  <= 1'b0;
            pend_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            phase_reg      <= phase_next;
            job_valid_reg  <= job_valid_next;
            pend_valid_reg <= pend_valid_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    // payload: no reset needed
    always_ff @(posedge clk)
    begin
        older_reg    <= older_next;
        newer_reg    <= newer_next;
        job_reg      <= job_next;
        pend_reg     <= pend_next;
        out_data_reg <= out_data_next;
    end

    // a second window only waits behind an occupied window register
    a_pend_behind_job: assert property (@(posedge clk) disable iff (!rst_n)
        pend_valid_reg |-> job_valid_reg)
        else $error("pending window without an occupied window register");

    // a last sample that closes a longer series queues its end window
    a_last_queues_end: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && in_data.last && (phase_reg != PHASE_EMPTY)) |=> pend_valid_reg)
        else $error("end window of series not queued");

    // the queued window is always the series end
    a_pend_is_end: assert property (@(posedge clk) disable iff (!rst_n)
        (pend_valid_reg && j_free) |=> (job_valid_reg && job_reg.series_end))
        else $error("queued window moved without series end");

endmodule

/* test/three_point_smoother_tb.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// three_point_smoother_tb: self-checking bench for the three-point smoother
// Directed series hit the sample extremes, every mode, one- and two-sample
// series, saturation, rounding ties and the unused register index. A long
// random part then runs series of random length with random settings. A
// transaction-level model predicts each result, and a monitor compares every
// output transaction against it. Sender bursts and receiver stalls are random.
// ----------------------------------------------------------------------------
module three_point_smoother_tb;
    import tps_pkg::*;

    localparam logic [CFG_IDX_W-1:0] REG_SPARE = 2'd3;
    localparam int  RANDOM_ITEMS = 1950;
    localparam int  IDLE_LIMIT   = 4000;
    localparam int  SETTLE_CYCLES = 8;
    localparam longint SAT_MAX = (64'sd1 <<< (SAMPLE_W - 1)) - 1;
    localparam longint SAT_MIN = -(64'sd1 <<< (SAMPLE_W - 1));

    logic                 clk = 1'b0;
    logic                 rst_n = 1'b0;
    logic                 in_valid = 1'b0;
    logic                 in_stall;
    in_t                  in_data = '0;
    logic                 out_valid;
    logic                 out_stall = 1'b0;
    out_t                 out_data;
    logic                 cfg_valid = 1'b0;
    logic                 cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [WEIGHT_W-1:0]  cfg_data = '0;

    // model copy of the registers and the window
    logic [1:0]                 mode_reg = MODE_RESET;
    logic [WEIGHT_W-1:0]        center_reg = CENTER_WEIGHT_RESET;
    logic [WEIGHT_W-1:0]        side_reg = SIDE_WEIGHT_RESET;
    logic signed [SAMPLE_W-1:0] older_q = '0;
    logic signed [SAMPLE_W-1:0] newer_q = '0;
    int                         held_count = 0;

    out_t expected_smoothed[$];
    int   mismatches = 0;
    int   burst_left = 0;
    int   stall_kind = 0;
    int   stall_left = 0;
    int   idle_cycles = 0;

    three_point_smoother DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always #10 clk = ~clk;

    function automatic logic signed [SAMPLE_W-1:0] round_clip(input longint acc);
        longint q;
        q = (acc + 64'sd32768) >>> 16;
        if (q > SAT_MAX)
            q = SAT_MAX;
        else if (q < SAT_MIN)
            q = SAT_MIN;
        return q[SAMPLE_W-1:0];
    endfunction

    function automatic longint median3(input longint a, input longint b, input longint c);
        longint lo, hi;
        lo = (a < b) ? a : b;
        hi = (a < b) ? b : a;
        if (c <= lo)
            return lo;
        if (c >= hi)
            return hi;
        return c;
    endfunction

    function automatic logic signed [SAMPLE_W-1:0] weigh(input longint a, input longint b,
                                                         input longint c);
        longint lo, hi;
        if (mode_reg == MODE_ORDER) begin
            lo = a;
            hi = a;
            if (b < lo) lo = b;
            if (c < lo) lo = c;
            if (b > hi) hi = b;
            if (c > hi) hi = c;
            return round_clip((lo + hi) * longint'(OS_EDGE_WEIGHT)
                              + median3(a, b, c) * longint'(OS_MID_WEIGHT));
        end
        // the unused mode code falls through to linear
        return round_clip((a + c) * longint'(side_reg) + b * longint'(center_reg));
    endfunction

    task automatic expect_smoothed(input logic signed [SAMPLE_W-1:0] v, input logic e);
        out_t r;
        r.smoothed = v;
        r.series_end = e;
        expected_smoothed.push_back(r);
    endtask

    task automatic filter_predict(input in_t item);
        longint x, a, b;
        logic   med;
        x = longint'($signed(item.sample));
        med = (mode_reg == MODE_MEDIAN);
        if (held_count == 0) begin
            if (item.last) begin
                expect_smoothed(item.sample, 1'b1);
            end
            else begin
                newer_q = item.sample;
                held_count = 1;
            end
        end
        else begin
            b = longint'(newer_q);
            a = (held_count == 1) ? b : longint'(older_q);
            if (med)
                expect_smoothed((held_count == 1) ? newer_q : SAMPLE_W'(median3(a, b, x)),
                                1'b0);
            else
                expect_smoothed(weigh(a, b, x), 1'b0);
            if (item.last) begin
                expect_smoothed(med ? item.sample : weigh(b, x, x), 1'b1);
                older_q = '0;
                newer_q = '0;
                held_count = 0;
            end
            else begin
                older_q = newer_q;
                newer_q = item.sample;
                held_count = 2;
            end
        end
    endtask

    task automatic report_mismatch(input string what, input int got, input int want);
        $display("ERROR %0t ns: %s: got %0d, expected %0d", $time, what, got, want);
        mismatches++;
    endtask

    // leaves in_valid high; the next send or a settle takes it from there
    task automatic send_sample(input logic [SAMPLE_W-1:0] value, input logic is_last);
        in_t item;
        if (burst_left == 0) begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 12)) @(posedge clk);
            burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(50, 200)
                                                     : $urandom_range(1, 12);
        end
        burst_left--;
        item.sample = value;
        item.last = is_last;
        in_valid <= 1'b1;
        in_data <= item;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        filter_predict(item);
    endtask

    // drop valid, wait for every expected result, then let the pipe empty
    task automatic settle_pipeline(input int extra);
        in_valid <= 1'b0;
        do
            @(posedge clk);
        while (expected_smoothed.size() > 0);
        repeat (extra) @(posedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [WEIGHT_W-1:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        case (idx)
            REG_MODE:          mode_reg = val[1:0];
            REG_CENTER_WEIGHT: center_reg = val;
            REG_SIDE_WEIGHT:   side_reg = val;
            default:           ;
        endcase
    endtask

    task automatic configure(input logic [WEIGHT_W-1:0] mode_word,
                             input logic [WEIGHT_W-1:0] center,
                             input logic [WEIGHT_W-1:0] side, input bit poke_spare);
        settle_pipeline(SETTLE_CYCLES);
        if (poke_spare)
            write_reg(REG_SPARE, 16'($urandom));
        write_reg(REG_MODE, mode_word);
        write_reg(REG_CENTER_WEIGHT, center);
        write_reg(REG_SIDE_WEIGHT, side);
        cfg_valid <= 1'b0;
    endtask

    function automatic logic [SAMPLE_W-1:0] pick_sample();
        logic [SAMPLE_W-1:0] v;
        case ($urandom_range(0, 9))
            0: v = 16'h7FFF;
            1: v = 16'h8000;
            2: v = 16'h7FFF - 16'($urandom_range(0, 15));
            3: v = 16'h8000 + 16'($urandom_range(0, 15));
            4: v = 16'($urandom_range(0, 16)) - 16'd8;
            default: v = 16'($urandom);
        endcase
        return v;
    endfunction

    function automatic logic [WEIGHT_W-1:0] pick_weight();
        case ($urandom_range(0, 5))
            0: return 16'h0000;
            1: return 16'hFFFF;
            2: return CENTER_WEIGHT_RESET;
            3: return SIDE_WEIGHT_RESET;
            default: return 16'($urandom);
        endcase
    endfunction

    task automatic test_reset_defaults();
        send_sample(16'h7FFF, 1'b0);
        send_sample(16'h8000, 1'b0);
        send_sample(16'h0000, 1'b0);
        send_sample(16'h0001, 1'b0);
        send_sample(16'hFFFF, 1'b1);
        settle_pipeline(SETTLE_CYCLES);
    endtask

    task automatic test_single_sample();
        send_sample(16'h8000, 1'b1);
        send_sample(16'h7FFF, 1'b1);
        settle_pipeline(SETTLE_CYCLES);
    endtask

    task automatic test_saturation();
        configure({14'h0000, MODE_LINEAR}, 16'hFFFF, 16'hFFFF, 1'b0);
        send_sample(16'h7FFF, 1'b0);
        send_sample(16'h7FFF, 1'b1);
        send_sample(16'h8000, 1'b0);
        send_sample(16'h8000, 1'b1);
    endtask

    task automatic test_median();
        configure({14'h3FFF, MODE_MEDIAN}, 16'h0000, 16'h0000, 1'b0);
        send_sample(16'd100, 1'b0);
        send_sample(-16'sd5, 1'b0);
        send_sample(16'd7, 1'b0);
        // hold the sender mid-series until the output side is empty
        settle_pipeline(0);
        send_sample(16'd7, 1'b0);
        send_sample(16'h7FFF, 1'b1);
        send_sample(16'h8000, 1'b0);
        send_sample(16'h7FFF, 1'b1);
    endtask

    task automatic test_order_statistic();
        configure({14'h1555, MODE_ORDER}, 16'hAAAA, 16'h5555, 1'b0);
        send_sample(16'h7FFF, 1'b0);
        send_sample(16'h8000, 1'b0);
        send_sample(16'h0000, 1'b0);
        send_sample(16'd20, 1'b1);
        send_sample(16'd9, 1'b0);
        send_sample(-16'sd9, 1'b1);
    endtask

    // unused mode code, spare index, and ties at +/- one half
    task automatic test_rounding_spare_mode();
        configure(16'h5557, 16'h8000, 16'h0000, 1'b1);
        send_sample(16'h0001, 1'b0);
        send_sample(16'hFFFF, 1'b0);
        send_sample(16'h0003, 1'b1);
    endtask

    task automatic test_random_series();
        int sent, len;
        logic [WEIGHT_W-1:0] mode_word;
        sent = 0;
        while (sent < RANDOM_ITEMS) begin
            if ($urandom_range(0, 5) == 0) begin
                mode_word = 16'($urandom);
                mode_word[1:0] = ($urandom_range(0, 7) == 0) ? 2'd3 : 2'($urandom_range(0, 2));
                configure(mode_word, pick_weight(), pick_weight(), $urandom_range(0, 3) == 0);
            end
            case ($urandom_range(0, 19))
                0:       len = 1;
                1:       len = 2;
                2:       len = $urandom_range(40, 120);
                default: len = $urandom_range(3, 20);
            endcase
            for (int k = 0; k < len; k++) begin
                if (k > 0 && $urandom_range(0, 99) == 0)
                    settle_pipeline(0);
                send_sample(pick_sample(), k == len - 1);
            end
            sent += len;
        end
        settle_pipeline(SETTLE_CYCLES);
    endtask

    // receiver stall pattern: free, light, heavy or periodic, in random stretches
    always @(posedge clk) begin
        if (stall_left == 0) begin
            stall_kind = $urandom_range(0, 3);
            stall_left = $urandom_range(16, 200);
        end
        else begin
            stall_left--;
        end
        case (stall_kind)
            0:       out_stall <= 1'b0;
            1:       out_stall <= ($urandom_range(0, 3) == 0);
            2:       out_stall <= ($urandom_range(0, 3) != 0);
            default: out_stall <= ((stall_left % 8) < 3);
        endcase
    end

    always @(posedge clk) begin : check_result
        out_t want;
        if (rst_n && out_valid && !out_stall) begin
            if (expected_smoothed.size() == 0) begin
                report_mismatch("result with no expectation waiting",
                                int'($signed(out_data.smoothed)), 0);
            end
            else begin
                want = expected_smoothed.pop_front();
                if (out_data.smoothed !== want.smoothed)
                    report_mismatch("smoothed", int'($signed(out_data.smoothed)),
                                    int'($signed(want.smoothed)));
                if (out_data.series_end !== want.series_end)
                    report_mismatch("series_end", int'(out_data.series_end),
                                    int'(want.series_end));
            end
        end
    end

    initial begin : watchdog
        while (idle_cycles < IDLE_LIMIT) begin
            @(posedge clk);
            if ((in_valid && !in_stall) || (out_valid && !out_stall)
                || (cfg_valid && cfg_ready))
                idle_cycles = 0;
            else
                idle_cycles++;
        end
        $display("three_point_smoother_tb NOT OK");
        $finish;
    end

    initial begin
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_reset_defaults();
        test_single_sample();
        test_saturation();
        test_median();
        test_order_statistic();
        test_rounding_spare_mode();
        test_random_series();
        if (mismatches == 0 && expected_smoothed.size() == 0)
            $display("three_point_smoother_tb OK");
        else
            $display("three_point_smoother_tb NOT OK");
        $finish;
    end

endmodule
